@@ rtl/core/eeg_pkg.sv @@
// Shared types and constants for the extended Euclidean GCD unit.
// Payload structs, field widths and the codes and buses of the shared arithmetic unit.
// No dependencies; compiled before every other file of the block.
package eeg_pkg;

  // Field widths
  localparam int OPND_W = 31;
  localparam int COEF_W = 32;
  localparam int CNT_W  = $clog2(OPND_W);

  // Shared arithmetic unit operations
  localparam logic ALU_SUB = 1'b0;
  localparam logic ALU_MUL = 1'b1;

  // Input transaction
  typedef struct packed {
    logic [OPND_W-1:0] operand_a;
    logic [OPND_W-1:0] operand_b;
  } eeg_in_t;

  // Result transaction
  typedef struct packed {
    logic        [OPND_W-1:0] divisor;
    logic signed [COEF_W-1:0] coeff_x;
    logic signed [COEF_W-1:0] coeff_y;
  } eeg_out_t;

  // Request to the shared arithmetic unit
  typedef struct packed {
    logic              op;
    logic [COEF_W-1:0] opa;
    logic [COEF_W-1:0] opb;
  } eeg_alu_ctl_t;

  // Answer from the shared arithmetic unit
  typedef struct packed {
    logic              borrow;
    logic [COEF_W-1:0] value;
  } eeg_alu_res_t;

endpackage

@@ rtl/core/extended_euclid_gcd_bezout_unit.sv @@
// Extended Euclidean unit: gcd(a, b) with Bezout coefficients x, y (a*x + b*y = gcd).
// One transaction at a time. Each quotient step runs the zero check, a restoring division over
// all 31 dividend bits and two multiply/subtract pairs; the last two use one shared unit.
// A new transaction is taken in the cycle after the result has been taken.
// Synchronous active-low reset returns the sequencer to idle; no clearing pass.
module extended_euclid_gcd_bezout_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  eeg_pkg::eeg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output eeg_pkg::eeg_out_t out_data
);
  import eeg_pkg::*;

  // Sequencer codes
  localparam int         ST_W     = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_CHECK = 3'd1;
  localparam logic [ST_W-1:0] ST_DIV   = 3'd2;
  localparam logic [ST_W-1:0] ST_MULS  = 3'd3;
  localparam logic [ST_W-1:0] ST_SUBS  = 3'd4;
  localparam logic [ST_W-1:0] ST_MULT  = 3'd5;
  localparam logic [ST_W-1:0] ST_SUBT  = 3'd6;
  localparam logic [ST_W-1:0] ST_DONE  = 3'd7;

  logic [ST_W-1:0]   state_r, state_nxt;
  logic [OPND_W-1:0] old_r_r, old_r_nxt;
  logic [OPND_W-1:0] r_r, r_nxt;
  logic [OPND_W-1:0] rem_r, rem_nxt;
  logic [OPND_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [COEF_W-1:0] old_s_r, old_s_nxt;
  logic [COEF_W-1:0] s_r, s_nxt;
  logic [COEF_W-1:0] old_t_r, old_t_nxt;
  logic [COEF_W-1:0] t_r, t_nxt;
  logic [COEF_W-1:0] prod_r, prod_nxt;

  eeg_alu_ctl_t      alu_ctl;
  eeg_alu_res_t      alu_res;
  logic [COEF_W-1:0] div_opa;
  logic              div_bit;
  logic [OPND_W-1:0] div_rem;

  eeg_alu u_alu (
    .ctl (alu_ctl),
    .res (alu_res)
  );

  // Restoring division step: shift the next dividend bit into the partial remainder
  assign div_opa = {rem_r, quo_r[OPND_W-1]};
  assign div_bit = !alu_res.borrow;
  assign div_rem = div_bit ? alu_res.value[OPND_W-1:0] : div_opa[OPND_W-1:0];

  // Handshake and result
  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = (state_r == ST_DONE);
  assign out_data.divisor = old_r_r;
  assign out_data.coeff_x = old_s_r;
  assign out_data.coeff_y = old_t_r;

  // Sequencer and datapath next state
  always_comb begin
    state_nxt = state_r;
    old_r_nxt = old_r_r;
    r_nxt     = r_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    old_s_nxt = old_s_r;
    s_nxt     = s_r;
    old_t_nxt = old_t_r;
    t_nxt     = t_r;
    prod_nxt  = prod_r;
    alu_ctl.op  = ALU_SUB;
    alu_ctl.opa = div_opa;
    alu_ctl.opb = {1'b0, r_r};
    unique case (state_r)
      ST_IDLE: begin
        // Load operands and the identity coefficient rows
        if (in_valid) begin
          old_r_nxt = in_data.operand_a;
          r_nxt     = in_data.operand_b;
          old_s_nxt = COEF_W'(1);
          s_nxt     = '0;
          old_t_nxt = '0;
          t_nxt     = COEF_W'(1);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Finish on a zero remainder, otherwise start the next division
        if (r_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          rem_nxt   = '0;
          quo_nxt   = old_r_r;
          cnt_nxt   = CNT_W'(OPND_W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = div_rem;
        quo_nxt = {quo_r[OPND_W-2:0], div_bit};
        cnt_nxt = cnt_r - 1'b1;
        // Last bit: advance the remainder pair
        if (cnt_r == '0) begin
          old_r_nxt = r_r;
          r_nxt     = div_rem;
          state_nxt = ST_MULS;
        end
      end
      ST_MULS: begin
        alu_ctl.op  = ALU_MUL;
        alu_ctl.opa = {1'b0, quo_r};
        alu_ctl.opb = s_r;
        prod_nxt    = alu_res.value;
        state_nxt   = ST_SUBS;
      end
      ST_SUBS: begin
        alu_ctl.opa = old_s_r;
        alu_ctl.opb = prod_r;
        old_s_nxt   = s_r;
        s_nxt       = alu_res.value;
        state_nxt   = ST_MULT;
      end
      ST_MULT: begin
        alu_ctl.op  = ALU_MUL;
        alu_ctl.opa = {1'b0, quo_r};
        alu_ctl.opb = t_r;
        prod_nxt    = alu_res.value;
        state_nxt   = ST_SUBT;
      end
      ST_SUBT: begin
        alu_ctl.opa = old_t_r;
        alu_ctl.opb = prod_r;
        old_t_nxt   = t_r;
        t_nxt       = alu_res.value;
        state_nxt   = ST_CHECK;
      end
      ST_DONE: begin
        // Hold the result until taken
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    old_r_r <= old_r_nxt;
    r_r     <= r_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    old_s_r <= old_s_nxt;
    s_r     <= s_nxt;
    old_t_r <= old_t_nxt;
    t_r     <= t_nxt;
    prod_r  <= prod_nxt;
  end

  // An accepted transaction always starts with the zero-remainder check
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_CHECK))
    else $error("accepted transaction did not enter the check state");

  // Partial remainder stays below the divisor during division
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < r_r))
    else $error("partial remainder not below divisor");

  // A result is only offered once the remainder has reached zero
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (r_r == '0))
    else $error("result offered with nonzero remainder");

  // No new transaction is taken while a result is waiting
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

endmodule

@@ rtl/core/eeg_alu.sv @@
// Shared arithmetic unit of the extended Euclidean GCD unit.
// One subtractor with borrow out and one truncating multiplier; depends on eeg_pkg.
module eeg_alu (
  input  eeg_pkg::eeg_alu_ctl_t ctl,
  output eeg_pkg::eeg_alu_res_t res
);
  import eeg_pkg::*;

  logic [COEF_W:0]     diff;
  logic [2*COEF_W-1:0] prod_full;

  // Subtract with borrow, and multiply keeping the low word (same for signed and unsigned)
  assign diff      = {1'b0, ctl.opa} - {1'b0, ctl.opb};
  assign prod_full = ctl.opa * ctl.opb;

  // Select the result of the requested operation
  always_comb begin
    unique case (ctl.op)
      ALU_SUB: begin
        res.borrow = diff[COEF_W];
        res.value  = diff[COEF_W-1:0];
      end
      ALU_MUL: begin
        res.borrow = 1'b0;
        res.value  = prod_full[COEF_W-1:0];
      end
      default: begin
        res.borrow = 1'b0;
        res.value  = '0;
      end
    endcase
  end

endmodule

@@ bench/extended_euclid_gcd_bezout_unit_checker.sv @@
// Checker for the extended Euclidean GCD unit: watches both channels and predicts results.
// Depends on eeg_pkg for the payload structs and field widths.
`timescale 1ns / 100ps

module extended_euclid_gcd_bezout_unit_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  eeg_pkg::eeg_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  eeg_pkg::eeg_out_t out_data,
  output int                fail_count,
  output int                pending
);
  import eeg_pkg::*;

  // Quotient store of the predictor: twice the data width plus a margin
  localparam int QUOT_DEPTH = 72;

  typedef struct {
    eeg_in_t  opnds;
    eeg_out_t want;
  } gcd_due_t;

  gcd_due_t gcd_due[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Forward remainder pass records every quotient, backward pass rebuilds x and y
  function automatic eeg_out_t bezout_of(input logic [OPND_W-1:0] a,
                                         input logic [OPND_W-1:0] b);
    logic [63:0] quot [0:QUOT_DEPTH-1];
    int          steps;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] rem;
    logic [63:0] cx;
    logic [63:0] cy;
    logic [63:0] nx;
    eeg_out_t    res;
    hi    = {{(64-OPND_W){1'b0}}, a};
    lo    = {{(64-OPND_W){1'b0}}, b};
    steps = 0;
    cx    = 64'd1;
    cy    = 64'd0;
    while (lo != 64'd0 && steps < QUOT_DEPTH) begin
      rem          = hi % lo;
      quot[steps]  = hi / lo;
      steps++;
      hi           = lo;
      lo           = rem;
    end
    // Wraps modulo 2^64, which equals the signed result once truncated
    while (steps > 0) begin
      steps--;
      nx = cy;
      cy = cx - quot[steps] * cy;
      cx = nx;
    end
    res.divisor = hi[OPND_W-1:0];
    res.coeff_x = cx[COEF_W-1:0];
    res.coeff_y = cy[COEF_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // Compare accepted results, then queue the prediction for an accepted transaction
  always @(posedge clk) begin : watch
    gcd_due_t head;
    gcd_due_t entry;
    if (!rst_n) begin
      gcd_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (gcd_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: divisor %0d x %0d y %0d",
                                    out_data.divisor, out_data.coeff_x, out_data.coeff_y));
        end else begin
          head = gcd_due.pop_front();
          if (out_data.divisor !== head.want.divisor)
            report_mismatch($sformatf("a=%0d b=%0d divisor %0d, want %0d",
                                      head.opnds.operand_a, head.opnds.operand_b,
                                      out_data.divisor, head.want.divisor));
          if (out_data.coeff_x !== head.want.coeff_x)
            report_mismatch($sformatf("a=%0d b=%0d coeff_x %0d, want %0d",
                                      head.opnds.operand_a, head.opnds.operand_b,
                                      out_data.coeff_x, head.want.coeff_x));
          if (out_data.coeff_y !== head.want.coeff_y)
            report_mismatch($sformatf("a=%0d b=%0d coeff_y %0d, want %0d",
                                      head.opnds.operand_a, head.opnds.operand_b,
                                      out_data.coeff_y, head.want.coeff_y));
        end
      end
      if (in_valid && !in_stall) begin
        entry.opnds = in_data;
        entry.want  = bezout_of(in_data.operand_a, in_data.operand_b);
        gcd_due.push_back(entry);
      end
    end
    pending = gcd_due.size();
  end

endmodule

@@ bench/extended_euclid_gcd_bezout_unit_test.sv @@
// Top of the bench for the extended Euclidean GCD unit: clock, reset, stimulus and verdict.
// Depends on eeg_pkg, the unit itself and extended_euclid_gcd_bezout_unit_checker.
`timescale 1ns / 100ps

module extended_euclid_gcd_bezout_unit_test;
  import eeg_pkg::*;

  localparam logic [OPND_W-1:0] OPND_MAX   = {OPND_W{1'b1}};
  localparam int                RAND_ITEMS = 400;
  localparam int                DRAIN      = 2000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  eeg_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  eeg_out_t out_data;
  int       fail_count;
  int       pending;

  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  extended_euclid_gcd_bezout_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  extended_euclid_gcd_bezout_unit_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Offer one operand pair in bursts; drop valid for a random gap between bursts
  task automatic offer_pair(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : $urandom_range(1, 2000);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid          <= 1'b1;
    in_data.operand_a <= a;
    in_data.operand_b <= b;
    burst_left--;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver stalls in stretches: free running, random, or mostly held off
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(1, 40);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 1) != 0);
      end
      default: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  initial begin
    logic [63:0]       p;
    logic [63:0]       q;
    logic [63:0]       nxt;
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic [OPND_W-1:0] t;
    logic [OPND_W-1:0] g;
    int                steps;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero operands, ones and full-scale values
    offer_pair('0, '0);
    offer_pair(31'd5, '0);
    offer_pair('0, 31'd7);
    offer_pair(OPND_MAX, '0);
    offer_pair('0, OPND_MAX);
    offer_pair(OPND_MAX, OPND_MAX);
    offer_pair(31'd1, 31'd1);
    offer_pair(OPND_MAX, 31'd1);
    offer_pair(31'd1, OPND_MAX);
    offer_pair(OPND_MAX, OPND_MAX - 31'd1);
    // Both orders of one pair; with the first operand smaller the roles swap on the first quotient
    offer_pair(31'd12, 31'd18);
    offer_pair(31'd18, 31'd12);
    // Consecutive Fibonacci numbers give the longest quotient chain
    offer_pair(31'd1836311903, 31'd1134903170);
    offer_pair(31'd1134903170, 31'd1836311903);
    // Powers of two, alternating bit patterns and a large pair near full scale
    offer_pair(31'h4000_0000, 31'h2000_0000);
    offer_pair(31'h5555_5555, 31'h2AAA_AAAA);
    offer_pair(31'd2147483629, 31'd2147483587);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          a = OPND_W'($urandom());
          b = OPND_W'($urandom());
        end
        4: begin
          a = OPND_W'($urandom_range(0, 255));
          b = OPND_W'($urandom_range(0, 255));
        end
        5, 6: begin
          // Shared factor so the divisor is not usually one
          g = OPND_W'($urandom_range(1, 65535));
          a = g * 31'($urandom_range(0, 32767));
          b = g * 31'($urandom_range(0, 32767));
        end
        7, 8: begin
          // Fibonacci-like pair from a random seed pair
          p     = 64'($urandom_range(1, 20));
          q     = p + 64'($urandom_range(0, 20));
          steps = $urandom_range(3, 44);
          for (int k = 0; k < steps; k++) begin
            nxt = p + q;
            if (nxt <= {33'd0, OPND_MAX}) begin
              p = q;
              q = nxt;
            end
          end
          a = q[OPND_W-1:0];
          b = p[OPND_W-1:0];
          if ($urandom_range(0, 1) != 0) begin
            t = a;
            a = b;
            b = t;
          end
        end
        default: begin
          // Degenerate pairs: a zero, a one or equal operands
          a = OPND_W'($urandom());
          case ($urandom_range(0, 3))
            0: b = '0;
            1: b = 31'd1;
            2: b = a;
            default: begin
              b = a;
              a = '0;
            end
          endcase
        end
      endcase
      offer_pair(a, b);
    end
    in_valid <= 1'b0;

    // Let the checker log the last transaction, then wait out outstanding results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #60000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
